[rtl/wpan_mac_header_parser_macros.svh]
// Assertion macros for the frame parser.
`ifndef WPAN_MAC_HEADER_PARSER_MACROS_SVH
`define WPAN_MAC_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define WMHP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wpan_mac_header_parser: implication check failed");

`define WMHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wpan_mac_header_parser: next-cycle check failed");

`else

`define WMHP_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define WMHP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/wmhp_pkg.sv]
package wmhp_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] frame_control;
    logic [7:0]  seq_num;
    logic [15:0] dest_pan;
    logic [15:0] src_pan;
    logic [63:0] dst_mac;
    logic [63:0] src_mac;
    logic [4:0]  header_len;
    logic [6:0]  payload_len;
  } result_item_t;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_TOO_SHORT   = 3'd1;
  localparam logic [2:0] STATUS_BAD_CRC     = 3'd2;
  localparam logic [2:0] STATUS_NON_DATA    = 3'd3;
  localparam logic [2:0] STATUS_HDR_OVERRUN = 3'd4;
  localparam logic [2:0] STATUS_TOO_LONG    = 3'd5;

  localparam int CFG_DATA_W = 7;
  localparam logic CFG_FCS_PRESENT   = 1'b0;
  localparam logic CFG_MIN_FRAME_LEN = 1'b1;

  localparam int HDR_BYTES = 23;

  localparam logic [2:0] FT_DATA   = 3'd1;
  localparam logic [2:0] FT_ACK    = 3'd2;
  localparam logic [1:0] FRAME_VER2 = 2'd2;
  localparam logic [1:0] AM_NONE   = 2'd0;
  localparam logic [1:0] AM_SHORT  = 2'd2;
  localparam logic [1:0] AM_EXT    = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [4:0] addr_len(input logic [1:0] mode);
    case (mode)
      AM_SHORT: addr_len = 5'd2;
      AM_EXT:   addr_len = 5'd8;
      default:  addr_len = 5'd0;
    endcase
  endfunction

endpackage

[rtl/wpan_mac_header_parser.sv]
// Channel   Direction  Payload        Handshake
// byte      in         byte_item_t    byte_valid / byte_stall
// result    out        result_item_t  result_valid / result_stall
// config    in         cfg_data       cfg_we, cfg_index
//
// One byte per cycle unless stalled; results are registered from the input register.
// The CRC update and header field selection are combinational and sit in the same cycle.
// Reset (rst, synchronous) empties both registers and clears the frame state.
// byte_stall rises only while a last byte waits for a stalled result register.
`include "wpan_mac_header_parser_macros.svh"

module wpan_mac_header_parser
  import wmhp_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 127
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  byte_item_t            byte_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_item_t          result_item,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_LEN);

  logic        fcs_present;
  logic [6:0]  min_frame_len;

  logic        a_valid;
  logic [7:0]  a_byte;
  logic        a_last;
  logic        a_adv;
  logic        go;

  logic [15:0] crc_accum;
  logic [7:0]  byte_count;
  logic [7:0]  d0;
  logic [7:0]  d1;
  logic [7:0]  hdr [HDR_BYTES];

  logic [15:0] crc_next;
  logic [7:0]  hb [HDR_BYTES];
  logic [HDR_BYTES*8-1:0] hv;
  logic [HDR_BYTES*8-1:0] sh1, sh2, sh3, sh4;

  logic [15:0] fc;
  logic        has_dp, has_sp, dp_on, sp_on;
  logic [4:0]  p1, p2, p3, p4, hl;
  logic [15:0] dpan, span;
  logic [63:0] daddr, saddr;
  logic [8:0]  rawlen, flen, pl_full;
  logic [15:0] crc_exp;
  logic        too_short, too_long, bad_crc, overrun;
  result_item_t result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcs_present   <= 1'b1;
      min_frame_len <= 7'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FCS_PRESENT:   fcs_present   <= cfg_data[0];
        CFG_MIN_FRAME_LEN: min_frame_len <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign a_adv      = !a_last || !result_valid || !result_stall;
  assign go         = a_valid && a_adv;
  assign byte_stall = a_valid && !a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      a_valid <= 1'b1;
    end else if (go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      a_byte <= byte_item.frame_byte;
      a_last <= byte_item.last_byte;
    end
  end

  assign crc_next = (byte_count >= 8'd2) ? crc_step(crc_accum, bit_rev8(d1)) : crc_accum;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum  <= '0;
      byte_count <= '0;
    end else if (go) begin
      if (a_last) begin
        crc_accum  <= '0;
        byte_count <= '0;
      end else begin
        crc_accum <= crc_next;
        if (byte_count != 8'hff) begin
          byte_count <= byte_count + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !a_last) begin
      d1 <= d0;
      d0 <= a_byte;
      if (byte_count < 8'(HDR_BYTES)) begin
        hdr[byte_count[4:0]] <= a_byte;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      if (8'(k) < byte_count) begin
        hb[k] = hdr[k];
      end else if (8'(k) == byte_count) begin
        hb[k] = a_byte;
      end else begin
        hb[k] = 8'h00;
      end
      hv[8*k +: 8] = hb[k];
    end
  end

  always_comb begin
    fc = {hb[1], hb[0]};
    has_dp = 1'b0;
    has_sp = 1'b0;
    if (fc[13:12] == FRAME_VER2) begin
      has_dp = (fc[11:10] == AM_NONE) ? fc[6] : !fc[6];
    end else if (fc[2:0] != FT_ACK) begin
      has_sp = !fc[6] && (fc[15:14] != AM_NONE);
      has_dp = fc[11:10] != AM_NONE;
    end
    dp_on = (fc[11:10] != AM_NONE) && has_dp;
    sp_on = (fc[15:14] != AM_NONE) && has_sp;

    p1 = fc[8] ? 5'd2 : 5'd3;
    p2 = p1 + (dp_on ? 5'd2 : 5'd0);
    p3 = p2 + addr_len(fc[11:10]);
    p4 = p3 + (sp_on ? 5'd2 : 5'd0);
    hl = p4 + addr_len(fc[15:14]);

    sh1 = hv >> {p1, 3'b000};
    sh2 = hv >> {p2, 3'b000};
    sh3 = hv >> {p3, 3'b000};
    sh4 = hv >> {p4, 3'b000};

    dpan = dp_on ? sh1[15:0] : 16'h0000;
    case (fc[11:10])
      AM_SHORT: daddr = {48'h0, sh2[15:0]};
      AM_EXT:   daddr = sh2[63:0];
      default:  daddr = '0;
    endcase
    if (fc[15:14] == AM_NONE) begin
      span = 16'h0000;
    end else begin
      span = sp_on ? sh3[15:0] : dpan;
    end
    case (fc[15:14])
      AM_SHORT: saddr = {48'h0, sh4[15:0]};
      AM_EXT:   saddr = sh4[63:0];
      default:  saddr = '0;
    endcase
  end

  always_comb begin
    rawlen    = {1'b0, byte_count} + 9'd1;
    too_short = (rawlen < {2'b00, min_frame_len}) || (fcs_present && rawlen < 9'd2);
    too_long  = rawlen > MAX_LEN;
    crc_exp   = {bit_rev8(crc_next[7:0]), bit_rev8(crc_next[15:8])};
    bad_crc   = fcs_present && (crc_exp != {a_byte, d0});
    flen      = fcs_present ? rawlen - 9'd2 : rawlen;
    overrun   = {4'b0000, hl} > flen;
    pl_full   = flen - {4'b0000, hl};

    result_next = '0;
    if (too_short) begin
      result_next.status = STATUS_TOO_SHORT;
    end else if (too_long) begin
      result_next.status = STATUS_TOO_LONG;
    end else if (bad_crc) begin
      result_next.status = STATUS_BAD_CRC;
    end else if (overrun) begin
      result_next.status        = STATUS_HDR_OVERRUN;
      result_next.frame_control = fc;
      result_next.header_len    = hl;
    end else begin
      result_next.status        = (fc[2:0] == FT_DATA) ? STATUS_OK : STATUS_NON_DATA;
      result_next.frame_control = fc;
      result_next.seq_num       = fc[8] ? 8'h00 : hb[2];
      result_next.dest_pan      = dpan;
      result_next.src_pan       = span;
      result_next.dst_mac       = daddr;
      result_next.src_mac       = saddr;
      result_next.header_len    = hl;
      result_next.payload_len   = (pl_full > 9'd127) ? 7'h7f : pl_full[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go && a_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && a_last) begin
      result_item <= result_next;
    end
  end

  `WMHP_ASSERT_IMPLY(a_nonlast_flows, clk, rst, a_valid && !a_last, !byte_stall)
  `WMHP_ASSERT_IMPLY(a_reject_empty, clk, rst,
    result_valid && (result_item.status == STATUS_TOO_SHORT ||
    result_item.status == STATUS_TOO_LONG || result_item.status == STATUS_BAD_CRC),
    result_item.frame_control == 16'h0000 && result_item.header_len == 5'd0)
  `WMHP_ASSERT_IMPLY(a_overrun_fields, clk, rst,
    result_valid && result_item.status == STATUS_HDR_OVERRUN,
    result_item.dst_mac == 64'h0 && result_item.src_mac == 64'h0 &&
    result_item.payload_len == 7'd0)
  `WMHP_ASSERT_NEXT(a_last_clears, clk, rst, go && a_last,
    byte_count == 8'd0 && crc_accum == 16'h0000 && result_valid)

endmodule
